### rtl/u8nm_pkg.sv
`default_nettype none

package u8nm_pkg;

  localparam int MAX_CHARS = 64;
  localparam int CNT_W     = $clog2(MAX_CHARS + 1);
  localparam int IDX_W     = $clog2(MAX_CHARS);
  localparam int SUM_W     = CNT_W + 1;
  localparam int CODE_W    = 21;

  // Diacritics folded to their base letter
  localparam logic [CODE_W-1:0] CP_A       = CODE_W'(97);
  localparam logic [CODE_W-1:0] CP_A_BREVE = CODE_W'(259);
  localparam logic [CODE_W-1:0] CP_A_CIRC  = CODE_W'(226);
  localparam logic [CODE_W-1:0] CP_I       = CODE_W'(105);
  localparam logic [CODE_W-1:0] CP_I_CIRC  = CODE_W'(238);
  localparam logic [CODE_W-1:0] CP_S       = CODE_W'(115);
  localparam logic [CODE_W-1:0] CP_S_CED   = CODE_W'(351);
  localparam logic [CODE_W-1:0] CP_T       = CODE_W'(116);
  localparam logic [CODE_W-1:0] CP_T_CED   = CODE_W'(355);

  function automatic logic [CODE_W-1:0] fold_char(input logic [CODE_W-1:0] u);
    logic [CODE_W-1:0] r;
    r = u;
    if (u == CP_A_BREVE || u == CP_A_CIRC) r = CP_A;
    else if (u == CP_I_CIRC) r = CP_I;
    else if (u == CP_S_CED) r = CP_S;
    else if (u == CP_T_CED) r = CP_T;
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/utf8_near_match_compare_top.sv
// Result: after an end request of the second string the block passes through a start state,
//   skips the walk when the counts differ by more than one, else walks prefix then suffix,
//   and loads the result from the finish state, where it waits while out_stall holds the output.
// Throughput: one byte request per cycle while idle; in_stall stays high during the
//   compare, which walks both character memories a pair at a time through a registered read.
// Reset: synchronous active-low rst_n clears counts, decoder, flags and output valid;
//   character memories are not cleared, only entries below the counts are read.
`default_nettype none

module utf8_near_match_compare_top (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic in_string_select,
  input  wire logic in_has_byte,
  input  wire logic [7:0] in_byte_value,
  input  wire logic in_end_of_string,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic      out_near_match,
  output logic      out_overflow
);
  import u8nm_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_START   = 7'b0000010,
    ST_PRE_RD  = 7'b0000100,
    ST_PRE_CMP = 7'b0001000,
    ST_SUF_RD  = 7'b0010000,
    ST_SUF_CMP = 7'b0100000,
    ST_FIN     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CODE_W-1:0] first_mem  [MAX_CHARS];
  logic [CODE_W-1:0] second_mem [MAX_CHARS];
  logic [CODE_W-1:0] rd_first_r, rd_second_r;

  logic [CNT_W-1:0]  first_count_r, first_count_nxt;
  logic [CNT_W-1:0]  second_count_r, second_count_nxt;
  logic [CODE_W-1:0] partial_r, partial_nxt;
  logic [1:0]        pending_r, pending_nxt;
  logic              ovf_seen_r, ovf_seen_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  trim_r, trim_nxt;
  logic              res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_match_r, out_match_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              accept;
  logic              store_en;
  logic [CODE_W-1:0] store_code;
  logic              wr_first, wr_second;
  logic [IDX_W-1:0]  raddr_first, raddr_second;
  logic [SUM_W-1:0]  walk_sum, walk_sum_p1;
  logic [SUM_W-1:0]  n1_ext, n2_ext;
  logic              walk_more;
  logic              suf_done_ok;
  logic              pair_match;
  logic              out_free;
  logic [CNT_W-1:0]  suf_first, suf_second;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Byte decoder
  always_comb begin
    store_en    = 1'b0;
    store_code  = '0;
    partial_nxt = partial_r;
    pending_nxt = pending_r;
    if (accept && in_has_byte) begin
      if (pending_r != 2'd0) begin
        partial_nxt = {partial_r[CODE_W-7:0], in_byte_value[5:0]};
        pending_nxt = pending_r - 2'd1;
        if (pending_r == 2'd1) begin
          store_en    = 1'b1;
          store_code  = {partial_r[CODE_W-7:0], in_byte_value[5:0]};
          partial_nxt = '0;
        end
      end else if (in_byte_value[7] == 1'b0) begin
        store_en   = 1'b1;
        store_code = {{(CODE_W-8){1'b0}}, in_byte_value};
      end else if (in_byte_value[7:5] == 3'b110) begin
        partial_nxt = {{(CODE_W-5){1'b0}}, in_byte_value[4:0]};
        pending_nxt = 2'd1;
      end else if (in_byte_value[7:4] == 4'b1110) begin
        partial_nxt = {{(CODE_W-4){1'b0}}, in_byte_value[3:0]};
        pending_nxt = 2'd2;
      end else if (in_byte_value[7:3] == 5'b11110) begin
        partial_nxt = {{(CODE_W-3){1'b0}}, in_byte_value[2:0]};
        pending_nxt = 2'd3;
      end
    end
    if (accept && in_end_of_string) begin
      partial_nxt = '0;
      pending_nxt = 2'd0;
    end
  end

  assign wr_first  = store_en && !in_string_select && (first_count_r < CNT_W'(MAX_CHARS));
  assign wr_second = store_en && in_string_select && (second_count_r < CNT_W'(MAX_CHARS));

  always_ff @(posedge clk) begin
    if (wr_first) begin
      first_mem[first_count_r[IDX_W-1:0]] <= store_code;
    end
    if (wr_second) begin
      second_mem[second_count_r[IDX_W-1:0]] <= store_code;
    end
    rd_first_r  <= first_mem[raddr_first];
    rd_second_r <= second_mem[raddr_second];
  end

  // Walk addressing: prefix at pos, suffix at count-1-trim
  assign n1_ext      = {1'b0, first_count_r};
  assign n2_ext      = {1'b0, second_count_r};
  assign walk_sum    = {1'b0, pos_r} + {1'b0, trim_r};
  assign walk_sum_p1 = walk_sum + SUM_W'(1);
  assign walk_more   = (walk_sum < n1_ext) && (walk_sum < n2_ext);
  assign suf_done_ok = (n1_ext <= walk_sum_p1) && (n2_ext <= walk_sum_p1);
  assign suf_first   = first_count_r - trim_r - CNT_W'(1);
  assign suf_second  = second_count_r - trim_r - CNT_W'(1);
  assign raddr_first  = (state_r == ST_SUF_RD) ? suf_first[IDX_W-1:0] : pos_r[IDX_W-1:0];
  assign raddr_second = (state_r == ST_SUF_RD) ? suf_second[IDX_W-1:0] : pos_r[IDX_W-1:0];

  // Shared compare unit
  assign pair_match = (fold_char(rd_first_r) == fold_char(rd_second_r));

  always_comb begin
    state_nxt        = state_r;
    first_count_nxt  = first_count_r;
    second_count_nxt = second_count_r;
    ovf_seen_nxt     = ovf_seen_r;
    pos_nxt          = pos_r;
    trim_nxt         = trim_r;
    res_nxt          = res_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_match_nxt    = out_match_r;
    out_ovf_nxt      = out_ovf_r;

    if (wr_first) first_count_nxt = first_count_r + CNT_W'(1);
    if (wr_second) second_count_nxt = second_count_r + CNT_W'(1);
    if (store_en && !wr_first && !wr_second) ovf_seen_nxt = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (accept && in_end_of_string && in_string_select) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        pos_nxt  = '0;
        trim_nxt = '0;
        if ((n1_ext > n2_ext + SUM_W'(1)) || (n2_ext > n1_ext + SUM_W'(1))) begin
          res_nxt   = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_PRE_RD;
        end
      end
      ST_PRE_RD: begin
        if (walk_more) begin
          state_nxt = ST_PRE_CMP;
        end else begin
          // prefix covers one string
          res_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end
      end
      ST_PRE_CMP: begin
        if (pair_match) begin
          pos_nxt   = pos_r + CNT_W'(1);
          state_nxt = ST_PRE_RD;
        end else begin
          state_nxt = ST_SUF_RD;
        end
      end
      ST_SUF_RD: begin
        if (walk_more) begin
          state_nxt = ST_SUF_CMP;
        end else begin
          res_nxt   = suf_done_ok;
          state_nxt = ST_FIN;
        end
      end
      ST_SUF_CMP: begin
        if (pair_match) begin
          trim_nxt  = trim_r + CNT_W'(1);
          state_nxt = ST_SUF_RD;
        end else begin
          res_nxt   = suf_done_ok;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_match_nxt    = res_r;
          out_ovf_nxt      = ovf_seen_r;
          first_count_nxt  = '0;
          second_count_nxt = '0;
          ovf_seen_nxt     = 1'b0;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      first_count_r  <= '0;
      second_count_r <= '0;
      partial_r      <= '0;
      pending_r      <= 2'd0;
      ovf_seen_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      first_count_r  <= first_count_nxt;
      second_count_r <= second_count_nxt;
      partial_r      <= partial_nxt;
      pending_r      <= pending_nxt;
      ovf_seen_r     <= ovf_seen_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    trim_r      <= trim_nxt;
    res_r       <= res_nxt;
    out_match_r <= out_match_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_near_match = out_match_r;
  assign out_overflow   = out_ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    first_count_r <= CNT_W'(MAX_CHARS) && second_count_r <= CNT_W'(MAX_CHARS))
    else $error("character count beyond capacity");

  a_pre_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PRE_CMP |-> (pos_r < first_count_r) && (pos_r < second_count_r))
    else $error("prefix walk read past a stored string");

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_free) |=>
      out_valid_r && first_count_r == '0 && second_count_r == '0 && !ovf_seen_r)
    else $error("result load did not clear the stores");

  a_end_drops_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_end_of_string) |=> pending_r == 2'd0 && partial_r == '0)
    else $error("pending sequence survived an end request");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result shown outside the finish step");

endmodule

`default_nettype wire

### tb/sv/tb.sv
module tb;
  import u8nm_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 400;
  localparam int ITEM_TARGET    = 1850;
  localparam logic SEL_FIRST    = 1'b0;
  localparam logic SEL_SECOND   = 1'b1;

  typedef struct packed {
    logic       sel;
    logic       has;
    logic [7:0] data;
    logic       eos;
    logic       drain;
  } byte_req_t;

  typedef struct packed {
    logic near;
    logic ovf;
  } verdict_t;

  logic       clk;
  logic       rst_n            = 1'b0;
  logic       in_valid         = 1'b0;
  logic       in_stall;
  logic       in_string_select = 1'b0;
  logic       in_has_byte      = 1'b0;
  logic [7:0] in_byte_value    = 8'h00;
  logic       in_end_of_string = 1'b0;
  logic       out_valid;
  logic       out_stall        = 1'b0;
  logic       out_near_match;
  logic       out_overflow;

  byte_req_t         req_q[$];
  verdict_t          verdict_q[$];
  logic [CODE_W-1:0] word_a[$];
  logic [CODE_W-1:0] word_b[$];
  logic              next_drain = 1'b0;
  byte_req_t         cur_req;
  int                reqs_done = 0;
  int                errors    = 0;

  // predicted block state
  logic [CODE_W-1:0] m_first[MAX_CHARS];
  logic [CODE_W-1:0] m_second[MAX_CHARS];
  int                m_first_n  = 0;
  int                m_second_n = 0;
  logic [CODE_W-1:0] m_partial  = '0;
  int                m_pending  = 0;
  logic              m_ovf      = 1'b0;

  utf8_near_match_compare_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_string_select (in_string_select),
    .in_has_byte      (in_has_byte),
    .in_byte_value    (in_byte_value),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_near_match   (out_near_match),
    .out_overflow     (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [CODE_W-1:0] base_letter(input logic [CODE_W-1:0] c);
    logic [CODE_W-1:0] b;
    b = c;
    if (c == CP_A_BREVE || c == CP_A_CIRC) b = CP_A;
    else if (c == CP_I_CIRC) b = CP_I;
    else if (c == CP_S_CED) b = CP_S;
    else if (c == CP_T_CED) b = CP_T;
    return b;
  endfunction

  task automatic append_char(input logic sel, input logic [CODE_W-1:0] c);
    if (sel == SEL_FIRST) begin
      if (m_first_n < MAX_CHARS) begin
        m_first[m_first_n] = c;
        m_first_n++;
      end else begin
        m_ovf = 1'b1;
      end
    end else begin
      if (m_second_n < MAX_CHARS) begin
        m_second[m_second_n] = c;
        m_second_n++;
      end else begin
        m_ovf = 1'b1;
      end
    end
  endtask

  function automatic logic strings_near();
    int i, j1, j2, d;
    d = m_first_n - m_second_n;
    if (d > 1 || d < -1) return 1'b0;
    i = 0;
    while (i < m_first_n && i < m_second_n &&
           base_letter(m_first[i]) == base_letter(m_second[i]))
      i++;
    if (i == m_first_n || i == m_second_n) return 1'b1;
    j1 = m_first_n - 1;
    j2 = m_second_n - 1;
    while (j1 >= i && j2 >= i && base_letter(m_first[j1]) == base_letter(m_second[j2])) begin
      j1--;
      j2--;
    end
    return (j1 <= i && j2 <= i);
  endfunction

  task automatic absorb_request(input byte_req_t r);
    verdict_t v;
    if (r.has) begin
      if (m_pending != 0) begin
        // any byte counts as a continuation while a sequence is open
        m_partial = {m_partial[CODE_W-7:0], r.data[5:0]};
        m_pending--;
        if (m_pending == 0) begin
          append_char(r.sel, m_partial);
          m_partial = '0;
        end
      end else if (!r.data[7]) begin
        append_char(r.sel, CODE_W'(r.data));
      end else if (r.data[7:5] == 3'b110) begin
        m_partial = CODE_W'(r.data[4:0]);
        m_pending = 1;
      end else if (r.data[7:4] == 4'b1110) begin
        m_partial = CODE_W'(r.data[3:0]);
        m_pending = 2;
      end else if (r.data[7:3] == 5'b11110) begin
        m_partial = CODE_W'(r.data[2:0]);
        m_pending = 3;
      end
    end
    if (r.eos) begin
      m_partial = '0;
      m_pending = 0;
      if (r.sel == SEL_SECOND) begin
        v.near = strings_near();
        v.ovf  = m_ovf;
        verdict_q.push_back(v);
        m_first_n  = 0;
        m_second_n = 0;
        m_ovf      = 1'b0;
      end
    end
  endtask

  task automatic push_req(input logic sel, input logic has, input logic [7:0] data,
                          input logic eos);
    byte_req_t r;
    r.sel   = sel;
    r.has   = has;
    r.data  = data;
    r.eos   = eos;
    r.drain = next_drain;
    next_drain = 1'b0;
    req_q.push_back(r);
  endtask

  function automatic logic [7:0] cont_byte(input logic [5:0] bits);
    logic [1:0] top;
    top = ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'b10;
    return {top, bits};
  endfunction

  task automatic push_char(input logic sel, input logic [CODE_W-1:0] c, input logic last);
    if (c < 21'h80) begin
      push_req(sel, 1'b1, c[7:0], last);
    end else if (c < 21'h800) begin
      push_req(sel, 1'b1, {3'b110, c[10:6]}, 1'b0);
      push_req(sel, 1'b1, cont_byte(c[5:0]), last);
    end else if (c < 21'h10000) begin
      push_req(sel, 1'b1, {4'b1110, c[15:12]}, 1'b0);
      push_req(sel, 1'b1, cont_byte(c[11:6]), 1'b0);
      push_req(sel, 1'b1, cont_byte(c[5:0]), last);
    end else begin
      push_req(sel, 1'b1, {5'b11110, c[20:18]}, 1'b0);
      push_req(sel, 1'b1, cont_byte(c[17:12]), 1'b0);
      push_req(sel, 1'b1, cont_byte(c[11:6]), 1'b0);
      push_req(sel, 1'b1, cont_byte(c[5:0]), last);
    end
  endtask

  function automatic logic [CODE_W-1:0] rand_code();
    logic [CODE_W-1:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        case ($urandom_range(0, 4))
          0: c = CP_A;
          1: c = CP_I;
          2: c = CP_S;
          3: c = CP_T;
          default: c = CP_A + CODE_W'(1);
        endcase
      end
      4, 5: begin
        case ($urandom_range(0, 4))
          0: c = CP_A_BREVE;
          1: c = CP_A_CIRC;
          2: c = CP_I_CIRC;
          3: c = CP_S_CED;
          default: c = CP_T_CED;
        endcase
      end
      6: c = CODE_W'($urandom_range(0, 127));
      7: c = CODE_W'($urandom_range(128, 2047));
      8: c = CODE_W'($urandom_range(2048, 65535));
      default: c = CODE_W'($urandom_range(65536, 2097151));
    endcase
    return c;
  endfunction

  // one string of the pair, closed in one of several ways
  task automatic push_word(input logic sel, input logic use_b);
    int n, k, style;
    n = use_b ? word_b.size() : word_a.size();
    style = (n == 0) ? 0 : $urandom_range(0, 3);
    for (k = 0; k < n; k++)
      push_char(sel, use_b ? word_b[k] : word_a[k], style == 3 && k == n - 1);
    case (style)
      0: push_req(sel, 1'b0, 8'($urandom), 1'b1);
      1: push_req(sel, 1'b1, 8'h80 | 8'($urandom_range(0, 63)), 1'b1);
      2: push_req(sel, 1'b1, {3'b110, 5'($urandom)}, 1'b1);
      default: ;
    endcase
  endtask

  task automatic push_pair();
    int len, k, n;
    logic swap;
    len = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
    word_a.delete();
    for (k = 0; k < len; k++) word_a.push_back(rand_code());
    word_b = word_a;
    case ($urandom_range(0, 6))
      1: if (word_b.size() > 0) word_b[$urandom_range(0, word_b.size() - 1)] = rand_code();
      2: word_b.insert($urandom_range(0, word_b.size()), rand_code());
      3: if (word_b.size() > 0) word_b.delete($urandom_range(0, word_b.size() - 1));
      4: begin
        // swap letters with their accented forms and back
        for (k = 0; k < word_b.size(); k++) begin
          if ($urandom_range(0, 1)) begin
            if (word_b[k] == CP_A) word_b[k] = $urandom_range(0, 1) ? CP_A_BREVE : CP_A_CIRC;
            else if (word_b[k] == CP_I) word_b[k] = CP_I_CIRC;
            else if (word_b[k] == CP_S) word_b[k] = CP_S_CED;
            else if (word_b[k] == CP_T) word_b[k] = CP_T_CED;
            else word_b[k] = base_letter(word_b[k]);
          end
        end
      end
      5: begin
        for (k = 0; k < 2; k++)
          if (word_b.size() > 0) word_b[$urandom_range(0, word_b.size() - 1)] = rand_code();
      end
      6: begin
        word_b.delete();
        n = $urandom_range(0, 9);
        for (k = 0; k < n; k++) word_b.push_back(rand_code());
      end
      default: ;
    endcase
    swap = 1'($urandom_range(0, 1));
    push_word(SEL_FIRST, swap);
    // characters after the first string has ended still append to it
    if ($urandom_range(0, 7) == 0) push_char(SEL_FIRST, rand_code(), 1'b0);
    push_word(SEL_SECOND, !swap);
  endtask

  task automatic push_noise();
    int n, k;
    n = $urandom_range(1, 12);
    for (k = 0; k < n; k++)
      push_req(1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0, 8'($urandom),
               $urandom_range(0, 7) == 0);
    push_req(SEL_SECOND, 1'($urandom_range(0, 1)), 8'($urandom), 1'b1);
  endtask

  initial begin : stimulus
    int total_reqs;
    // accented a against plain a
    push_req(SEL_FIRST, 1'b1, 8'h61, 1'b1);
    push_req(SEL_SECOND, 1'b1, 8'hC4, 1'b0);
    push_req(SEL_SECOND, 1'b1, 8'h83, 1'b1);
    // two empty strings
    push_req(SEL_FIRST, 1'b0, 8'h00, 1'b1);
    push_req(SEL_SECOND, 1'b0, 8'hFF, 1'b1);
    // bad leads skipped, widest 4-byte form, unfinished tail dropped at the end
    push_req(SEL_FIRST, 1'b1, 8'h80, 1'b0);
    push_req(SEL_FIRST, 1'b1, 8'hFF, 1'b0);
    push_req(SEL_FIRST, 1'b1, 8'hF8, 1'b0);
    push_req(SEL_FIRST, 1'b1, 8'h00, 1'b0);
    push_req(SEL_FIRST, 1'b1, 8'hF7, 1'b0);
    push_req(SEL_FIRST, 1'b1, 8'hBF, 1'b0);
    push_req(SEL_FIRST, 1'b1, 8'hBF, 1'b0);
    push_req(SEL_FIRST, 1'b1, 8'hBF, 1'b0);
    push_req(SEL_FIRST, 1'b1, 8'hE2, 1'b1);
    // sequence split across strings lands where it completes
    push_req(SEL_SECOND, 1'b1, 8'h00, 1'b0);
    push_req(SEL_SECOND, 1'b1, 8'hF0, 1'b0);
    push_req(SEL_FIRST, 1'b1, 8'h9F, 1'b0);
    push_req(SEL_SECOND, 1'b1, 8'h98, 1'b0);
    push_req(SEL_FIRST, 1'b1, 8'h80, 1'b0);
    push_req(SEL_SECOND, 1'b1, 8'h7F, 1'b1);
    // continuation top bits ignored
    push_req(SEL_FIRST, 1'b1, 8'hC3, 1'b0);
    push_req(SEL_FIRST, 1'b1, 8'hFF, 1'b1);
    push_req(SEL_SECOND, 1'b1, 8'hC3, 1'b0);
    push_req(SEL_SECOND, 1'b1, 8'hBF, 1'b0);
    push_req(SEL_SECOND, 1'b0, 8'h00, 1'b1);

    next_drain = 1'b1;
    while (req_q.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 11) == 0) next_drain = 1'b1;
      if ($urandom_range(0, 3) == 0) push_noise();
      else push_pair();
    end
    total_reqs = req_q.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (reqs_done < total_reqs) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  int   gap_left  = 0;
  logic gap_burst = 1'b0;

  always @(posedge clk) begin : drive_requests
    logic sending;
    byte_req_t r;
    sending = in_valid;
    if (!rst_n) begin
      sending  = 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_request(cur_req);
        reqs_done++;
        sending = 1'b0;
        if ($urandom_range(0, 39) == 0) gap_burst = !gap_burst;
        gap_left = gap_burst ? 0 : $urandom_range(0, 3);
      end
      if (!sending) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (req_q.size() != 0 && !(req_q[0].drain && verdict_q.size() != 0)) begin
          // a drain request holds off until every pending result is out
          r = req_q.pop_front();
          cur_req = r;
          sending = 1'b1;
          in_string_select <= r.sel;
          in_has_byte      <= r.has;
          in_byte_value    <= r.data;
          in_end_of_string <= r.eos;
        end
      end
    end
    in_valid <= sending;
  end

  int   stall_left  = 0;
  logic stall_burst = 1'b0;

  always @(posedge clk) begin : check_results
    verdict_t v;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, got near_match %0b overflow %0b",
                   $time, out_near_match, out_overflow);
        end else begin
          v = verdict_q.pop_front();
          if (out_near_match !== v.near) begin
            errors++;
            $display("%0t: near_match mismatch: expected %0b, got %0b",
                     $time, v.near, out_near_match);
          end
          if (out_overflow !== v.ovf) begin
            errors++;
            $display("%0t: overflow mismatch: expected %0b, got %0b",
                     $time, v.ovf, out_overflow);
          end
        end
        if ($urandom_range(0, 39) == 0) stall_burst = !stall_burst;
        stall_left = stall_burst ? 0 : $urandom_range(0, 3);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

### filelist.f
rtl/u8nm_pkg.sv
rtl/utf8_near_match_compare_top.sv
tb/sv/tb.sv
